>>> hdl/mvlf_pkg.sv
// Shared constants for the multi-voice ladder filter: field widths, register
// and operation codes, and the fixed-point coefficients of the stage gain.
// No dependencies.
package mvlf_pkg;

  localparam int VOICE_COUNT_DEF  = 16;
  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int VOICE_W    = 4;
  localparam int CUTOFF_W   = 15;
  localparam int RES_W      = 16;
  localparam int RATE_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int GAIN_BITS  = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd2;

  // Operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Register values after reset
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 15'd1000;
  localparam logic [RES_W-1:0]    RES_RST    = 16'd32768;
  localparam logic [RATE_W-1:0]   RATE_RST   = 18'd48000;

  // Limits applied when forming w
  localparam logic [CUTOFF_W-1:0] CUTOFF_MIN = 15'd20;
  localparam logic [CUTOFF_W-1:0] CUTOFF_MAX = 15'd20000;
  localparam logic [RATE_W-1:0]   RATE_MIN   = 18'd8000;
  localparam logic [RATE_W-1:0]   RATE_MAX   = 18'd192000;

  // 2*pi in Q.29 and the gain polynomial coefficients in Q0.20
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [20:0] COEF_A     = 21'd1037251;
  localparam logic [18:0] COEF_B     = 19'd455292;
  localparam logic [17:0] COEF_C     = 18'd144808;
  localparam logic [14:0] COEF_D     = 15'd21181;

endpackage

>>> hdl/mvlf_gain.sv
// Stage gain sequencer: clamps cutoff and rate, divides 2*pi*fc by fs one
// quotient bit per cycle, then evaluates the gain polynomial on one shared
// multiplier. Depends on mvlf_pkg.
module mvlf_gain (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [mvlf_pkg::CUTOFF_W-1:0]         cutoff_hz,
  input  logic [mvlf_pkg::RATE_W-1:0]           sample_rate_hz,
  output logic                                  busy,
  output logic [mvlf_pkg::GAIN_BITS-1:0]        gain
);
  import mvlf_pkg::*;

  localparam int NUM_W   = 46;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int MA_W    = 36;
  localparam int MB_W    = 25;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int TERM_W  = PROD_W - 20;
  localparam int ACC_W   = 44;
  localparam int W1_W    = 25;
  localparam int W2_W    = 28;
  localparam int W3_W    = 32;
  localparam int W4_W    = 36;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);
  localparam logic signed [ACC_W-1:0] GAIN_MAX = ACC_W'((1 << GAIN_BITS) - 1);

  typedef enum logic [4:0] {
    G_IDLE, G_NUM, G_DLD, G_DIV, G_W1,
    G_M2, G_S2, G_M3, G_S3, G_M4, G_S4,
    G_MA, G_SA, G_MB, G_SB, G_MC, G_SC, G_MD, G_SD, G_CL
  } gstate_t;

  gstate_t                   state;
  logic [RATE_W-1:0]         fs_c;
  logic [NUM_W-1:0]          dq;
  logic [RATE_W-1:0]         rem;
  logic [CNT_W-1:0]          cnt;
  logic [W1_W-1:0]           w1;
  logic [W2_W-1:0]           w2;
  logic [W3_W-1:0]           w3;
  logic [W4_W-1:0]           w4;
  logic signed [ACC_W-1:0]   acc;
  logic [PROD_W-1:0]         mul_p;

  logic [CUTOFF_W-1:0]       fc_c;
  logic [MA_W-1:0]           mul_a;
  logic [MB_W-1:0]           mul_b;
  logic [RATE_W:0]           trial;
  logic                      qbit;
  logic [PROD_W-1:0]         rnd_sum;
  logic [TERM_W-1:0]         term;
  logic signed [ACC_W-1:0]   term_s;
  logic [W1_W+9:0]           w1_sum;

  assign busy = (state != G_IDLE);

  always_comb begin
    if (cutoff_hz < CUTOFF_MIN)      fc_c = CUTOFF_MIN;
    else if (cutoff_hz > CUTOFF_MAX) fc_c = CUTOFF_MAX;
    else                             fc_c = cutoff_hz;
  end

  // One restoring division step
  assign trial = {rem, dq[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, fs_c});

  assign rnd_sum = mul_p + PROD_W'(1 << 19);
  assign term    = rnd_sum[PROD_W-1:20];
  assign term_s  = signed'({3'b000, term});
  assign w1_sum  = {1'b0, dq[W1_W+8:0]} + (W1_W+10)'(256);

  always_comb begin
    case (state)
      G_NUM: begin
        mul_a = MA_W'(TWO_PI_Q29);
        mul_b = MB_W'(fc_c);
      end
      G_M2: begin
        mul_a = MA_W'(w1);
        mul_b = w1;
      end
      G_M3: begin
        mul_a = MA_W'(w2);
        mul_b = w1;
      end
      G_M4: begin
        mul_a = MA_W'(w3);
        mul_b = w1;
      end
      G_MA: begin
        mul_a = MA_W'(COEF_A);
        mul_b = w1;
      end
      G_MB: begin
        mul_a = MA_W'(w2);
        mul_b = MB_W'(COEF_B);
      end
      G_MC: begin
        mul_a = MA_W'(w3);
        mul_b = MB_W'(COEF_C);
      end
      G_MD: begin
        mul_a = w4;
        mul_b = MB_W'(COEF_D);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_NUM;
    end else begin
      case (state)
        G_IDLE: begin
          if (start) state <= G_NUM;
        end
        G_NUM: begin
          if (sample_rate_hz < RATE_MIN)      fs_c <= RATE_MIN;
          else if (sample_rate_hz > RATE_MAX) fs_c <= RATE_MAX;
          else                                fs_c <= sample_rate_hz;
          state <= G_DLD;
        end
        G_DLD: begin
          dq    <= mul_p[NUM_W-1:0];
          rem   <= '0;
          cnt   <= '0;
          state <= G_DIV;
        end
        G_DIV: begin
          rem <= qbit ? RATE_W'(trial - {1'b0, fs_c}) : trial[RATE_W-1:0];
          dq  <= {dq[NUM_W-2:0], qbit};
          cnt <= CNT_W'(cnt + 1'b1);
          if (cnt == CNT_LAST) state <= G_W1;
        end
        G_W1: begin
          w1    <= w1_sum[W1_W+8:9];
          state <= G_M2;
        end
        G_M2: state <= G_S2;
        G_S2: begin
          w2    <= term[W2_W-1:0];
          state <= G_M3;
        end
        G_M3: state <= G_S3;
        G_S3: begin
          w3    <= term[W3_W-1:0];
          state <= G_M4;
        end
        G_M4: state <= G_S4;
        G_S4: begin
          w4    <= term[W4_W-1:0];
          state <= G_MA;
        end
        G_MA: state <= G_SA;
        G_SA: begin
          acc   <= term_s;
          state <= G_MB;
        end
        G_MB: state <= G_SB;
        G_SB: begin
          acc   <= acc - term_s;
          state <= G_MC;
        end
        G_MC: state <= G_SC;
        G_SC: begin
          acc   <= acc + term_s;
          state <= G_MD;
        end
        G_MD: state <= G_SD;
        G_SD: begin
          acc   <= acc - term_s;
          state <= G_CL;
        end
        G_CL: begin
          if (acc < 0)             gain <= '0;
          else if (acc > GAIN_MAX) gain <= '1;
          else                     gain <= acc[GAIN_BITS-1:0];
          state <= G_IDLE;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/multi_voice_ladder_filter_unit.sv
// Top level of the multi-voice ladder filter: voice pole memory, the
// feedback and four-stage sample datapath, and the configuration registers.
// Depends on mvlf_pkg and mvlf_gain.

// A filter item reads the voice's pole entry at acceptance. The feedback
// multiply (S_FBM) and then the feedback subtract and clamp (S_FBS) follow.
// Each of the four poles then takes a multiply and an update on one shared
// multiplier. The next item is taken in the cycle after the result is
// registered, so filter items do not overlap; a result still waiting on the
// output holds the last update. A clear item is handled in the idle state
// itself. Each voice's four poles live in one memory word; a per-voice valid
// bit, cleared by reset and by a clear item, makes a fresh voice read as
// zero. After reset and after every write to the cutoff, resonance or rate
// register the stage gain is recomputed by the divider and the polynomial,
// and no item and no further register write is taken until it is done.
module multi_voice_ladder_filter_unit #(
  parameter int VOICE_COUNT  = mvlf_pkg::VOICE_COUNT_DEF,
  parameter int SAMPLE_WIDTH = mvlf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mvlf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mvlf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [mvlf_pkg::VOICE_W-1:0]        voice_index,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mvlf_pkg::VOICE_W-1:0]        voice_index_out,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
  import mvlf_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int AW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int MA_W  = 21;
  localparam int MBW   = SW + 1;
  localparam int MW    = MA_W + MBW;
  localparam int S0W   = SW + 8;
  localparam int SUMW  = SW + 3;
  localparam longint SMAX_L = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN_L = -(longint'(1) <<< (SW - 1));
  localparam longint LIM_L  = longint'(3) <<< (SW - 5);
  localparam logic signed [SUMW-1:0] SMAX   = SUMW'(SMAX_L);
  localparam logic signed [SUMW-1:0] SMIN   = SUMW'(SMIN_L);
  localparam logic signed [S0W-1:0]  S0_HI  = S0W'(LIM_L);
  localparam logic signed [S0W-1:0]  S0_LO  = S0W'(-LIM_L);
  localparam logic signed [MW-1:0]   HALF16 = MW'(32'sd32768);
  localparam logic signed [MW-1:0]   HALF20 = MW'(32'sd524288);

  typedef enum logic [2:0] {S_IDLE, S_FBM, S_FBS, S_STM, S_STS} state_t;

  function automatic logic signed [SW-1:0] sat_s(input logic signed [SUMW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SMAX)      r = SMAX[SW-1:0];
    else if (v < SMIN) r = SMIN[SW-1:0];
    else               r = v[SW-1:0];
    return r;
  endfunction

  // Configuration registers
  logic [CUTOFF_W-1:0]  cutoff_hz;
  logic [RES_W-1:0]     resonance;
  logic [RATE_W-1:0]    sample_rate_hz;
  logic                 cfg_hit;
  logic                 gain_busy;
  logic [GAIN_BITS-1:0] gain;

  // Sample datapath
  state_t                 state;
  logic [VOICE_COUNT-1:0] valid;
  logic                   vld_q;
  logic [AW-1:0]          addr;
  logic [VOICE_W-1:0]     voice;
  logic signed [SW-1:0]   x;
  logic signed [SW-1:0]   src;
  logic signed [SW-1:0]   pole [4];
  logic [1:0]             k;
  logic signed [MW-1:0]   mprod;

  logic [4*SW-1:0]        mem [VOICE_COUNT];
  logic [4*SW-1:0]        rdata;
  logic                   mem_we;

  logic [AW-1:0]          in_addr;
  logic                   in_range;
  logic                   out_free;
  logic [17:0]            r3;
  logic signed [SW-1:0]   p4_rd;
  logic signed [MA_W-1:0] ma;
  logic signed [MBW-1:0]  mb;
  logic signed [MW-1:0]   rnd16;
  logic signed [MW-1:0]   rnd20;
  logic signed [S0W-1:0]  fb;
  logic signed [S0W-1:0]  s0;
  logic signed [SW-1:0]   s0c;
  logic signed [SUMW-1:0] upd;
  logic signed [SW-1:0]   newp;

  assign cfg_ready = !gain_busy;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == CFG_CUTOFF || cfg_index == CFG_RESONANCE ||
                      cfg_index == CFG_RATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_hz      <= CUTOFF_RST;
      resonance      <= RES_RST;
      sample_rate_hz <= RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CUTOFF:    cutoff_hz      <= cfg_data[CUTOFF_W-1:0];
        CFG_RESONANCE: resonance      <= cfg_data[RES_W-1:0];
        CFG_RATE:      sample_rate_hz <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  mvlf_gain u_gain (
    .clk            (clk),
    .rst            (rst),
    .start          (cfg_hit),
    .cutoff_hz      (cutoff_hz),
    .sample_rate_hz (sample_rate_hz),
    .busy           (gain_busy),
    .gain           (gain)
  );

  assign in_ready = (state == S_IDLE) && !gain_busy;
  assign in_addr  = AW'(voice_index);
  assign in_range = (32'(voice_index) < VOICE_COUNT);
  assign out_free = !out_valid || out_ready;

  // Feedback gain 3r in Q2.16
  assign r3    = {2'b00, resonance} + {1'b0, resonance, 1'b0};
  assign p4_rd = vld_q ? signed'(rdata[4*SW-1:3*SW]) : '0;

  always_comb begin
    case (state)
      S_FBM: begin
        ma = signed'({3'b000, r3});
        mb = MBW'(p4_rd);
      end
      S_STM: begin
        ma = signed'({1'b0, gain});
        mb = MBW'(src) - MBW'(pole[k]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Feedback subtract and clamp to +/-1.5
  assign rnd16 = mprod + HALF16;
  assign fb    = S0W'(pole[3]) + S0W'(signed'(rnd16[MW-1:16]));
  assign s0    = S0W'(x) - fb;
  always_comb begin
    if (s0 > S0_HI)      s0c = S0_HI[SW-1:0];
    else if (s0 < S0_LO) s0c = S0_LO[SW-1:0];
    else                 s0c = s0[SW-1:0];
  end

  // One-pole update
  assign rnd20 = mprod + HALF20;
  assign upd   = SUMW'(pole[k]) + SUMW'(signed'(rnd20[MW-1:20]));
  assign newp  = sat_s(upd);

  assign mem_we = (state == S_STS) && (k == 2'd3) && out_free;

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= {newp, pole[2], pole[1], pole[0]};
    rdata <= mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      valid     <= '0;
    end else begin
      // drop the taken beat unless a new result lands in the same cycle
      if (out_valid && out_ready && !mem_we) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready && in_range) begin
            if (op == OP_CLEAR) begin
              valid[in_addr] <= 1'b0;
            end else begin
              vld_q <= valid[in_addr];
              addr  <= in_addr;
              voice <= voice_index;
              x     <= sample_in;
              state <= S_FBM;
            end
          end
        end
        S_FBM: begin
          for (int i = 0; i < 4; i++) begin
            pole[i] <= vld_q ? signed'(rdata[i*SW +: SW]) : '0;
          end
          mprod <= ma * mb;
          state <= S_FBS;
        end
        S_FBS: begin
          src   <= s0c;
          k     <= 2'd0;
          state <= S_STM;
        end
        S_STM: begin
          mprod <= ma * mb;
          state <= S_STS;
        end
        S_STS: begin
          if (k != 2'd3) begin
            pole[k] <= newp;
            src     <= newp;
            k       <= 2'(k + 2'd1);
            state   <= S_STM;
          end else if (out_free) begin
            // hold here while the previous result is still waiting
            pole[k]         <= newp;
            valid[addr]     <= 1'b1;
            out_valid       <= 1'b1;
            voice_index_out <= voice;
            sample_out      <= newp;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> test/tb_multi_voice_ladder_filter_unit.sv
// Self-checking testbench for multi_voice_ladder_filter_unit: random filter and
// clear beats with random gaps and stalls, a fixed-point ladder predictor per voice.
// Depends on mvlf_pkg and the filter RTL.
module tb_multi_voice_ladder_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mvlf_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int NV = VOICE_COUNT_DEF;
  localparam longint SAMPLE_HI = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) << (SW - 1));
  localparam longint DRIVE_LIMIT = 3 * (longint'(1) << (SW - 5));
  localparam longint GAIN_MAX = (longint'(1) << GAIN_BITS) - 1;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                 op;
    logic [VOICE_W-1:0]   voice;
    logic signed [SW-1:0] sample;
  } ladder_item_t;

  typedef struct packed {
    logic [VOICE_W-1:0]   voice;
    logic signed [SW-1:0] sample;
  } voice_sample_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op = OP_FILTER;
  logic [VOICE_W-1:0]    voice_index = '0;
  logic signed [SW-1:0]  sample_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VOICE_W-1:0]    voice_index_out;
  logic signed [SW-1:0]  sample_out;

  multi_voice_ladder_filter_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .voice_index(voice_index),
    .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .voice_index_out(voice_index_out),
    .sample_out(sample_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted filter state and register copies
  longint pole1 [NV];
  longint pole2 [NV];
  longint pole3 [NV];
  longint pole4 [NV];
  logic [CUTOFF_W-1:0]  cutoff_reg;
  logic [RES_W-1:0]     res_reg;
  logic [RATE_W-1:0]    rate_reg;
  logic [GAIN_BITS-1:0] stage_gain_q20;

  ladder_item_t  pending_items_q[$];
  voice_sample_t filtered_q[$];
  ladder_item_t  held_item;

  int  gap_left, stall_left, hold_left;
  bit  sender_steady, receiver_steady, hold_kick, hold_seen;
  int  cycle_count, fail_count, results_checked, filter_beats, clear_beats, cfg_writes;

  function automatic longint unsigned mul_q20(longint unsigned a, longint unsigned b);
    return (a * b + 64'd524288) >> 20;
  endfunction

  function automatic logic [GAIN_BITS-1:0] ladder_gain(logic [CUTOFF_W-1:0] fc_bits,
                                                       logic [RATE_W-1:0] fs_bits);
    longint unsigned fc, fs, w1, w2, w3, w4;
    longint g;
    fc = fc_bits;
    fs = fs_bits;
    if (fc < CUTOFF_MIN) fc = CUTOFF_MIN;
    if (fc > CUTOFF_MAX) fc = CUTOFF_MAX;
    if (fs < RATE_MIN) fs = RATE_MIN;
    if (fs > RATE_MAX) fs = RATE_MAX;
    // w in Q.29 first, then rounded to nearest Q.20
    w1 = ((64'(TWO_PI_Q29) * fc) / fs + 64'd256) >> 9;
    w2 = mul_q20(w1, w1);
    w3 = mul_q20(w2, w1);
    w4 = mul_q20(w3, w1);
    g = longint'(mul_q20(COEF_A, w1)) - longint'(mul_q20(COEF_B, w2))
      + longint'(mul_q20(COEF_C, w3)) - longint'(mul_q20(COEF_D, w4));
    if (g < 0) g = 0;
    if (g > GAIN_MAX) g = GAIN_MAX;
    return g[GAIN_BITS-1:0];
  endfunction

  function automatic longint clip_sample(longint v);
    if (v > SAMPLE_HI) return SAMPLE_HI;
    if (v < SAMPLE_LO) return SAMPLE_LO;
    return v;
  endfunction

  function automatic longint ladder_stage(longint p, longint src, logic [GAIN_BITS-1:0] g);
    return clip_sample(p + ((longint'(g) * (src - p) + 524288) >>> 20));
  endfunction

  task automatic set_ladder_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CUTOFF:    cutoff_reg = data[CUTOFF_W-1:0];
      CFG_RESONANCE: res_reg = data[RES_W-1:0];
      CFG_RATE:      rate_reg = data[RATE_W-1:0];
      default:       return;
    endcase
    stage_gain_q20 = ladder_gain(cutoff_reg, rate_reg);
  endtask

  task automatic apply_ladder_item(ladder_item_t it);
    longint x, fb, s0;
    int v;
    v = it.voice;
    if (it.op == OP_CLEAR) begin
      pole1[v] = 0;
      pole2[v] = 0;
      pole3[v] = 0;
      pole4[v] = 0;
      clear_beats++;
      return;
    end
    x = longint'($signed(it.sample));
    fb = pole4[v] + ((3 * longint'(res_reg) * pole4[v] + 32768) >>> 16);
    s0 = x - fb;
    if (s0 > DRIVE_LIMIT) s0 = DRIVE_LIMIT;
    if (s0 < -DRIVE_LIMIT) s0 = -DRIVE_LIMIT;
    pole1[v] = ladder_stage(pole1[v], s0, stage_gain_q20);
    pole2[v] = ladder_stage(pole2[v], pole1[v], stage_gain_q20);
    pole3[v] = ladder_stage(pole3[v], pole2[v], stage_gain_q20);
    pole4[v] = ladder_stage(pole4[v], pole3[v], stage_gain_q20);
    filtered_q.push_back('{voice: it.voice, sample: pole4[v][SW-1:0]});
    filter_beats++;
  endtask

  // Sender: one beat per item, random gap after each unless the phase is steady
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) apply_ladder_item(held_item);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items_q.size() > 0) begin
          held_item = pending_items_q.pop_front();
          op <= held_item.op;
          voice_index <= held_item.voice;
          sample_in <= held_item.sample;
          in_valid <= 1'b1;
          gap_left = sender_steady ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_result;
    voice_sample_t want;
    if (filtered_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("cycle %0d: result beat voice %0d sample %0d with nothing expected",
                 cycle_count, voice_index_out, sample_out);
      return;
    end
    want = filtered_q.pop_front();
    results_checked++;
    if (voice_index_out !== want.voice || sample_out !== want.sample) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("cycle %0d: expected voice %0d sample %0d, got voice %0d sample %0d",
                 cycle_count, want.voice, want.sample, voice_index_out, sample_out);
    end
  endtask

  // Receiver: random stall after each beat, plus a long hold when kicked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        stall_left = receiver_steady ? 0 : $urandom_range(0, 9);
      end
      if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, filtered_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_item(logic o, logic [VOICE_W-1:0] v, logic signed [SW-1:0] s);
    pending_items_q.push_back('{op: o, voice: v, sample: s});
  endtask

  function automatic ladder_item_t random_item(int voices);
    ladder_item_t it;
    int pick, a;
    it.op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_FILTER;
    if ($urandom_range(0, 7) == 0) it.voice = VOICE_W'($urandom);
    else it.voice = VOICE_W'($urandom_range(0, voices - 1));
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      it.sample = SW'($urandom);
    end else if (pick < 6) begin
      a = int'($urandom_range(0, 262143)) - 131072;
      it.sample = SW'(a);
    end else if (pick < 8) begin
      it.sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    end else begin
      // around +/-1.0, drives the feedback clamp
      a = (1 << (SW - 4)) + int'($urandom_range(0, 4095)) - 2048;
      it.sample = $urandom_range(0, 1) ? SW'(a) : SW'(-a);
    end
    return it;
  endfunction

  // Hold until sender, block and receiver have nothing left in flight
  task automatic wait_drained;
    do @(negedge clk);
    while (pending_items_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    set_ladder_reg(idx, data);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic random_config;
    if ($urandom_range(0, 1))
      write_reg(CFG_CUTOFF, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                         : CFG_DATA_W'($urandom_range(20, 20000)));
    if ($urandom_range(0, 1))
      write_reg(CFG_RESONANCE, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1))
      write_reg(CFG_RATE, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                       : CFG_DATA_W'($urandom_range(8000, 192000)));
    if ($urandom_range(0, 7) == 0)
      write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
  endtask

  task automatic run_phase(int count, int voices, bit steady_in, bit steady_out, bit long_hold);
    @(negedge clk);
    sender_steady <= steady_in;
    receiver_steady <= steady_out;
    if (long_hold) hold_kick <= ~hold_kick;
    repeat (count) pending_items_q.push_back(random_item(voices));
    wait_drained();
  endtask

  initial begin
    for (int v = 0; v < NV; v++) begin
      pole1[v] = 0;
      pole2[v] = 0;
      pole3[v] = 0;
      pole4[v] = 0;
    end
    cutoff_reg = CUTOFF_RST;
    res_reg = RES_RST;
    rate_reg = RATE_RST;
    stage_gain_q20 = ladder_gain(cutoff_reg, rate_reg);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: sample extremes, both operations, clear of live and fresh voices
    repeat (3) queue_item(OP_FILTER, 0, SAMPLE_MAX);
    repeat (3) queue_item(OP_FILTER, 0, SAMPLE_MIN);
    queue_item(OP_FILTER, 0, 0);
    queue_item(OP_FILTER, 0, 1);
    queue_item(OP_FILTER, 0, -1);
    queue_item(OP_FILTER, 15, 24'h555555);
    queue_item(OP_FILTER, 15, 24'hAAAAAA);
    queue_item(OP_FILTER, 15, SAMPLE_MAX);
    queue_item(OP_CLEAR, 0, 24'hFFFFFF);
    queue_item(OP_FILTER, 0, 1);
    queue_item(OP_CLEAR, 15, 0);
    queue_item(OP_FILTER, 15, SAMPLE_MIN);
    queue_item(OP_FILTER, 7, 0);
    queue_item(OP_CLEAR, 9, SAMPLE_MIN);
    queue_item(OP_FILTER, 9, SAMPLE_MAX);
    wait_drained();

    // Gain saturated high with full resonance
    write_reg(CFG_RESONANCE, 18'd65535);
    write_reg(CFG_CUTOFF, 18'd20000);
    run_phase(60, 2, 1'b1, 1'b1, 1'b0);
    // Polynomial below zero: gain clamps to zero
    write_reg(CFG_RATE, 18'd8000);
    run_phase(30, 4, 1'b0, 1'b0, 1'b0);
    // Both frequencies below their ranges, no resonance
    write_reg(CFG_CUTOFF, 18'd0);
    write_reg(CFG_RATE, 18'd0);
    write_reg(CFG_RESONANCE, 18'd0);
    run_phase(40, 4, 1'b0, 1'b1, 1'b0);
    // Both frequencies above their ranges, unused register index, long output hold
    write_reg(CFG_CUTOFF, 18'd32767);
    write_reg(CFG_RATE, 18'h3FFFF);
    write_reg(CFG_SPARE, 18'h3FFFF);
    run_phase(40, 16, 1'b1, 1'b0, 1'b1);
    write_reg(CFG_CUTOFF, 18'd1000);
    write_reg(CFG_RATE, 18'd48000);
    write_reg(CFG_RESONANCE, 18'd49152);

    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      run_phase(125, $urandom_range(1, NV), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0, ph % 5 == 2);
    end

    wait_drained();
    $display("Ran %0d filter beats and %0d clears over %0d register writes;",
             filter_beats, clear_beats, cfg_writes);
    $display("checked %0d results, %0d errors.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
